@@ rtl/core/pi_loop_pwm_with_telemetry_frame_core_defines.svh @@
// Assertion macros for the PI loop / PWM / telemetry core.
// No dependencies; included by the top level only.
`ifndef PI_LOOP_PWM_WITH_TELEMETRY_FRAME_CORE_DEFINES_SVH
`define PI_LOOP_PWM_WITH_TELEMETRY_FRAME_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PILP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define PILP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/pilp_pkg.sv @@
// Shared constants for the PI loop / PWM / telemetry core.
// No dependencies; used by the request interface and the top level.
package pilp_pkg;

   // Parameter defaults
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int ACC_WIDTH_DEF   = 32;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_SETPOINT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_NOW   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_PREV  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DUTY_SCALE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DUTY_MAX   = 3'd4;

   // Register reset values
   localparam logic signed [15:0] GAIN_NOW_RST   = 16'sd16384;
   localparam logic signed [15:0] GAIN_PREV_RST  = -16'sd16056;
   localparam logic [15:0]        DUTY_SCALE_RST = 16'd48011;
   localparam logic [15:0]        DUTY_MAX_RST   = 16'd3000;

   // Duty product is Q.28, integer part starts here
   localparam int DUTY_SHIFT = 28;

   // Telemetry frame
   localparam int         FRAME_LEN  = 9;
   localparam int         BYTE_IDX_W = 4;
   localparam logic [7:0] FRAME_HEAD = 8'h03;
   localparam logic [7:0] FRAME_TAIL = 8'hFC;
   localparam logic [7:0] TOGGLE_ON  = 8'hFF;
   localparam logic [7:0] TOGGLE_OFF = 8'h00;

endpackage

@@ rtl/core/pilp_req_if.sv @@
// Input channel: one sample pair per transaction.
// Depends on pilp_pkg.
interface pilp_req_if
   import pilp_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] reference_sample;
   logic [SAMPLE_BITS-1:0] feedback_sample;

   modport source (output valid, output reference_sample, output feedback_sample,
                   input ready);
   modport sink   (input valid, input reference_sample, input feedback_sample,
                   output ready);
endinterface

@@ rtl/core/pilp_rsp_if.sv @@
// Result channel: one telemetry byte plus the current duty per transaction.
// No dependencies.
interface pilp_rsp_if ();
   logic        valid;
   logic        ready;
   logic [7:0]  frame_byte;
   logic        frame_last;
   logic [15:0] duty;

   modport source (output valid, output frame_byte, output frame_last, output duty,
                   input ready);
   modport sink   (input valid, input frame_byte, input frame_last, input duty,
                   output ready);
endinterface

@@ rtl/core/pi_loop_pwm_with_telemetry_frame_core.sv @@
// Incremental PI controller with PWM duty scaling and a nine-byte telemetry frame.
// Depends on pilp_pkg, pilp_req_if, pilp_rsp_if and the core defines header.
//
//   channel | direction | transaction
//   --------+-----------+------------------------------------------------
//   req     | in        | reference_sample, feedback_sample
//   rsp     | out       | frame_byte, frame_last, duty (nine per req)
//   csr     | in        | register write, index 0..4, no wait, no read-back
//
// Each sample is accepted, then passes 8 sequencer steps around the single shared
// 17x25 multiplier (two gain products and their sums, saturation, two partial
// products for the duty scale and their sum, clamp), then the nine frame bytes go out.
// rsp stalls hold the current byte; req is ready only while idle.
// Reset is synchronous and active high, sets the registers to their defaults and
// clears integrator, previous error and toggle.

`include "pi_loop_pwm_with_telemetry_frame_core_defines.svh"

module pi_loop_pwm_with_telemetry_frame_core
   import pilp_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   pilp_req_if.sink               req,
   pilp_rsp_if.source             rsp,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // Widths of the shared multiplier and the accumulation paths
   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 25;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int CHUNK   = MUL_B_W - 1;
   localparam int MAG_W   = 2 * CHUNK;
   localparam int GPROD_W = 16 + SAMPLE_BITS + 1;
   localparam int SUM_W   = ((ACC_WIDTH > GPROD_W) ? ACC_WIDTH : GPROD_W) + 2;
   localparam int DACC_W  = ACC_WIDTH + 16;
   localparam int WIDE_W  = PROD_W + CHUNK;
   localparam int ERR_W   = SAMPLE_BITS + 1;

   localparam logic signed [SUM_W-1:0] SUM_MAX =
      {{(SUM_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL0  = 4'd1;
   localparam logic [3:0] S_MUL1  = 4'd2;
   localparam logic [3:0] S_ADD1  = 4'd3;
   localparam logic [3:0] S_SAT   = 4'd4;
   localparam logic [3:0] S_DLO   = 4'd5;
   localparam logic [3:0] S_DHI   = 4'd6;
   localparam logic [3:0] S_DADD  = 4'd7;
   localparam logic [3:0] S_CLAMP = 4'd8;
   localparam logic [3:0] S_SEND  = 4'd9;

   // Frame byte positions
   localparam logic [BYTE_IDX_W-1:0] B_HEAD   = 4'd0;
   localparam logic [BYTE_IDX_W-1:0] B_TOGGLE = 4'd1;
   localparam logic [BYTE_IDX_W-1:0] B_REF_LO = 4'd2;
   localparam logic [BYTE_IDX_W-1:0] B_REF_HI = 4'd3;
   localparam logic [BYTE_IDX_W-1:0] B_FB_LO  = 4'd4;
   localparam logic [BYTE_IDX_W-1:0] B_FB_HI  = 4'd5;
   localparam logic [BYTE_IDX_W-1:0] B_SP_LO  = 4'd6;
   localparam logic [BYTE_IDX_W-1:0] B_SP_HI  = 4'd7;
   localparam logic [BYTE_IDX_W-1:0] B_LAST   = BYTE_IDX_W'(FRAME_LEN - 1);

   // Configuration registers
   logic [SAMPLE_BITS-1:0] setpoint_ff;
   logic signed [15:0]     gain_now_ff;
   logic signed [15:0]     gain_prev_ff;
   logic [15:0]            duty_scale_ff;
   logic [15:0]            duty_max_ff;

   // Control state
   logic [3:0]            state_ff, state_in;
   logic [BYTE_IDX_W-1:0] byte_idx_ff, byte_idx_in;
   logic                  toggle_ff;
   logic signed [ACC_WIDTH-1:0] integ_ff;
   logic signed [ERR_W-1:0]     last_err_ff;

   // Datapath registers
   logic [SAMPLE_BITS-1:0]      ref_ff;
   logic [SAMPLE_BITS-1:0]      fb_ff;
   logic signed [ERR_W-1:0]     err_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [SUM_W-1:0]     sum_ff;
   logic signed [ACC_WIDTH-1:0] sat_in;
   logic [MAG_W-1:0]            mag_ff;
   logic [DACC_W-1:0]           dacc_ff;
   logic [DACC_W-1:0]           dint;
   logic [15:0]                 duty_ff, duty_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;

   logic req_fire, rsp_fire;
   logic [15:0] ref16, fb16, sp16;
   logic [7:0]  frame_byte;

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff   <= '0;
         gain_now_ff   <= GAIN_NOW_RST;
         gain_prev_ff  <= GAIN_PREV_RST;
         duty_scale_ff <= DUTY_SCALE_RST;
         duty_max_ff   <= DUTY_MAX_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_SETPOINT:   setpoint_ff   <= csr_write_data[SAMPLE_BITS-1:0];
            REG_GAIN_NOW:   gain_now_ff   <= csr_write_data;
            REG_GAIN_PREV:  gain_prev_ff  <= csr_write_data;
            REG_DUTY_SCALE: duty_scale_ff <= csr_write_data;
            REG_DUTY_MAX:   duty_max_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL0: begin
            mul_a = MUL_A_W'(gain_now_ff);
            mul_b = MUL_B_W'(err_ff);
         end
         S_MUL1: begin
            mul_a = MUL_A_W'(gain_prev_ff);
            mul_b = MUL_B_W'(last_err_ff);
         end
         S_DLO: begin
            mul_a = signed'({1'b0, duty_scale_ff});
            mul_b = signed'({1'b0, mag_ff[CHUNK-1:0]});
         end
         S_DHI: begin
            mul_a = signed'({1'b0, duty_scale_ff});
            mul_b = signed'({1'b0, mag_ff[MAG_W-1:CHUNK]});
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Saturation of the accumulator sum
   always_comb begin
      if (sum_ff > SUM_MAX) begin
         sat_in = SUM_MAX[ACC_WIDTH-1:0];
      end else if (sum_ff < SUM_MIN) begin
         sat_in = SUM_MIN[ACC_WIDTH-1:0];
      end else begin
         sat_in = sum_ff[ACC_WIDTH-1:0];
      end
   end

   // Integer part of the scaled duty and clamp; zero while the setpoint is zero
   assign dint = dacc_ff >> DUTY_SHIFT;

   always_comb begin
      if (setpoint_ff == '0) begin
         duty_in = '0;
      end else if (dint > DACC_W'(duty_max_ff)) begin
         duty_in = duty_max_ff;
      end else begin
         duty_in = dint[15:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      byte_idx_in = byte_idx_ff;
      case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_MUL0;
         S_MUL0:  state_in = S_MUL1;
         S_MUL1:  state_in = S_ADD1;
         S_ADD1:  state_in = S_SAT;
         S_SAT:   state_in = S_DLO;
         S_DLO:   state_in = S_DHI;
         S_DHI:   state_in = S_DADD;
         S_DADD:  state_in = S_CLAMP;
         S_CLAMP: begin
            state_in    = S_SEND;
            byte_idx_in = B_HEAD;
         end
         S_SEND: begin
            if (rsp_fire) begin
               if (byte_idx_ff == B_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  byte_idx_in = byte_idx_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers and loop history
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         byte_idx_ff <= B_HEAD;
         toggle_ff   <= 1'b0;
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else begin
         state_ff    <= state_in;
         byte_idx_ff <= byte_idx_in;
         if (req_fire) toggle_ff <= ~toggle_ff;
         if (state_ff == S_SAT) begin
            if (setpoint_ff == '0) begin
               integ_ff    <= '0;
               last_err_ff <= '0;
            end else begin
               integ_ff    <= sat_in;
               last_err_ff <= err_ff;
            end
         end
      end
   end

   // Datapath steps
   always_ff @(posedge clock) begin
      if (req_fire) begin
         ref_ff <= req.reference_sample;
         fb_ff  <= req.feedback_sample;
         err_ff <= signed'({1'b0, setpoint_ff} - {1'b0, req.feedback_sample});
      end
      case (state_ff)
         S_MUL0, S_MUL1, S_DLO, S_DHI: prod_ff <= mul_p;
         default: ;
      endcase
      case (state_ff)
         S_MUL1: sum_ff <= SUM_W'(integ_ff) + SUM_W'(prod_ff);
         S_ADD1: sum_ff <= sum_ff + SUM_W'(prod_ff);
         S_SAT: begin
            if (sat_in > 0) begin
               mag_ff <= MAG_W'(sat_in[ACC_WIDTH-2:0]);
            end else begin
               mag_ff <= '0;
            end
         end
         S_DHI:   dacc_ff <= DACC_W'($unsigned(prod_ff));
         S_DADD:  dacc_ff <= dacc_ff + DACC_W'(WIDE_W'($unsigned(prod_ff)) << CHUNK);
         S_CLAMP: duty_ff <= duty_in;
         default: ;
      endcase
   end

   // Frame byte select
   assign ref16 = 16'(ref_ff);
   assign fb16  = 16'(fb_ff);
   assign sp16  = 16'(setpoint_ff);

   always_comb begin
      case (byte_idx_ff)
         B_HEAD:   frame_byte = FRAME_HEAD;
         B_TOGGLE: frame_byte = toggle_ff ? TOGGLE_ON : TOGGLE_OFF;
         B_REF_LO: frame_byte = ref16[7:0];
         B_REF_HI: frame_byte = ref16[15:8];
         B_FB_LO:  frame_byte = fb16[7:0];
         B_FB_HI:  frame_byte = fb16[15:8];
         B_SP_LO:  frame_byte = sp16[7:0];
         B_SP_HI:  frame_byte = sp16[15:8];
         default:  frame_byte = FRAME_TAIL;
      endcase
   end

   // Channel outputs
   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = (state_ff == S_SEND);
   assign rsp.frame_byte = frame_byte;
   assign rsp.frame_last = (byte_idx_ff == B_LAST);
   assign rsp.duty       = duty_ff;

   // Checks
   `PILP_ASSERT_IMP(a_no_overlap, clock, reset, req.ready, !rsp.valid, "req ready while sending")
   `PILP_ASSERT_IMP(a_tail_byte, clock, reset, rsp.valid && rsp.frame_last, rsp.frame_byte == FRAME_TAIL, "bad frame tail")
   `PILP_ASSERT_IMP(a_duty_clamp, clock, reset, rsp.valid, rsp.duty <= duty_max_ff, "duty above clamp")
   `PILP_ASSERT_NXT(a_back_idle, clock, reset, rsp_fire && rsp.frame_last, req.ready, "not idle after frame")

endmodule
